@@ sv/start_seq_cobs_frame_parser_assert.svh @@
// assertion macros for the start-sequence cobs frame parser checker
// expects signals named clk and rst in the scope of use
`ifndef START_SEQ_COBS_FRAME_PARSER_ASSERT_SVH
`define START_SEQ_COBS_FRAME_PARSER_ASSERT_SVH

// same-cycle implication, held off during reset
`define SSCFP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("frame parser check failed");

// next-cycle implication, held off during reset
`define SSCFP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("frame parser check failed");

`endif

@@ sv/sscfp_pkg.sv @@
// shared types and constants for the start-sequence cobs frame parser
// no dependencies
package sscfp_pkg;

  // default sizing
  localparam int MAX_FRAME_DEF = 256;
  localparam int SYNC_MAX_DEF  = 4;

  // fixed field widths
  localparam int BYTE_W   = 8;
  localparam int SYNC_W   = 32;
  localparam int SLEN_W   = 3;
  localparam int LIMIT_W  = 9;
  localparam int PCOUNT_W = 10;
  localparam int THRESH_W = 11;
  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SYNC_BYTES  = 2'd0,
    CFG_SYNC_LENGTH = 2'd1,
    CFG_FRAME_LIMIT = 2'd2,
    CFG_CSUM_ENABLE = 2'd3
  } cfg_index_t;

  // end-of-frame status codes
  typedef enum logic [1:0] {
    FS_OK       = 2'd0,
    FS_CSUM_BAD = 2'd1,
    FS_OVERFLOW = 2'd2
  } frame_status_t;

endpackage

@@ sv/sscfp_rx_if.sv @@
// received byte channel: valid/ready handshake with one raw byte
// depends on sscfp_pkg
interface sscfp_rx_if;
  logic                          valid;
  logic                          ready;
  logic [sscfp_pkg::BYTE_W-1:0]  rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

@@ sv/sscfp_frame_if.sv @@
// result channel: decoded byte, frame end marker and status
// depends on sscfp_pkg
interface sscfp_frame_if;
  logic                          valid;
  logic                          ready;
  logic [sscfp_pkg::BYTE_W-1:0]  out_byte;
  logic                          data_valid;
  logic                          frame_end;
  logic [1:0]                    frame_status;

  modport source (output valid, output out_byte, output data_valid, output frame_end,
                  output frame_status, input ready);
  modport sink   (input valid, input out_byte, input data_valid, input frame_end,
                  input frame_status, output ready);
endinterface

@@ sv/start_seq_cobs_frame_parser.sv @@
// start-sequence hunter and on-the-fly cobs decoder with checksum status
// depends on sscfp_pkg, sscfp_rx_if, sscfp_frame_if
//
//   channel | dir | payload                                        | handshake
//   rx      | in  | rx_byte                                        | valid/ready
//   frm     | out | out_byte, data_valid, frame_end, frame_status | valid/ready
//   cfg     | in  | cfg_index, cfg_data                            | cfg_we only
//
// one byte per cycle sustained while frm takes results; a byte passes the input
// register, then the result register, and the decode step sits between them
// rst is synchronous and clears the valid flags, control state and sequencing; config goes to its defaults
// a stall on frm holds the result register; rx takes one more byte only into an
// empty input register, and drops ready until the result is taken
module start_seq_cobs_frame_parser #(
  parameter int MAX_FRAME = sscfp_pkg::MAX_FRAME_DEF,
  parameter int SYNC_MAX  = sscfp_pkg::SYNC_MAX_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  sscfp_rx_if.sink                         rx,
  sscfp_frame_if.source                    frm,
  input  logic                             cfg_we,
  input  logic [sscfp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sscfp_pkg::SYNC_W-1:0]     cfg_data
);

  localparam int MC_W = $clog2(SYNC_MAX + 1);
  localparam int BW   = sscfp_pkg::BYTE_W;
  localparam int PW   = sscfp_pkg::PCOUNT_W;
  localparam int TW   = sscfp_pkg::THRESH_W;

  // configuration registers
  logic [sscfp_pkg::SYNC_W-1:0]  sync_bytes;
  logic [sscfp_pkg::SLEN_W-1:0]  sync_length;
  logic [sscfp_pkg::LIMIT_W-1:0] frame_limit;
  logic                          checksum_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_bytes      <= '0;
      sync_length     <= '0;
      frame_limit     <= sscfp_pkg::LIMIT_W'(64);
      checksum_enable <= 1'b1;
    end else if (cfg_we) begin
      unique case (sscfp_pkg::cfg_index_t'(cfg_index))
        sscfp_pkg::CFG_SYNC_BYTES:  sync_bytes      <= cfg_data;
        sscfp_pkg::CFG_SYNC_LENGTH: sync_length     <= cfg_data[sscfp_pkg::SLEN_W-1:0];
        sscfp_pkg::CFG_FRAME_LIMIT: frame_limit     <= cfg_data[sscfp_pkg::LIMIT_W-1:0];
        sscfp_pkg::CFG_CSUM_ENABLE: checksum_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // input register
  logic          in_valid;
  logic [BW-1:0] in_byte;
  logic          advance;

  assign advance  = in_valid && (!frm.valid || frm.ready);
  assign rx.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (rx.ready) begin
      in_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      in_byte <= rx.rx_byte;
    end
  end

  // parser state
  logic [MC_W-1:0] match_count, match_count_next;
  logic [PW-1:0]   packet_count, packet_count_next;
  logic [BW-1:0]   lead_code, lead_code_next;
  logic [BW-1:0]   block_remaining, block_remaining_next;
  logic            block_was_full, block_was_full_next;
  logic [BW-1:0]   held_byte, held_byte_next;
  logic            held_valid, held_valid_next;
  logic [BW-1:0]   running_sum, running_sum_next;
  logic            decode_halted, decode_halted_next;

  // effective configuration
  logic [MC_W-1:0] len;
  logic [TW-1:0]   lim;
  logic [TW-1:0]   thresh;
  logic [2*sscfp_pkg::SYNC_W-1:0] sync_ext;
  logic [2:0]      sel;
  logic [BW-1:0]   expect_byte;

  always_comb begin
    if (4'(sync_length) > 4'(SYNC_MAX)) len = MC_W'(SYNC_MAX);
    else                                len = MC_W'(sync_length);
    if (TW'(frame_limit) > TW'(MAX_FRAME)) lim = TW'(MAX_FRAME);
    else                                   lim = TW'(frame_limit);
    thresh      = lim + TW'(checksum_enable) + TW'(2);
    sync_ext    = {{sscfp_pkg::SYNC_W{1'b0}}, sync_bytes};
    sel         = 3'(match_count);
    expect_byte = sync_ext[{sel, 3'b000} +: BW];
  end

  // result of this step
  logic                     res_v;
  logic [BW-1:0]            res_byte;
  logic                     res_dv;
  logic                     res_fe;
  sscfp_pkg::frame_status_t res_st;

  // frame start values and decode scratch
  logic          e_hv, e_halt, e_bwf;
  logic [BW-1:0] e_hb, e_rs, e_br;
  logic          have;
  logic [BW-1:0] dec;

  // decode step
  always_comb begin
    match_count_next     = match_count;
    packet_count_next    = packet_count;
    lead_code_next       = lead_code;
    block_remaining_next = block_remaining;
    block_was_full_next  = block_was_full;
    held_byte_next       = held_byte;
    held_valid_next      = held_valid;
    running_sum_next     = running_sum;
    decode_halted_next   = decode_halted;
    res_v    = 1'b0;
    res_byte = '0;
    res_dv   = 1'b0;
    res_fe   = 1'b0;
    res_st   = sscfp_pkg::FS_OK;
    e_hv     = held_valid;
    e_hb     = held_byte;
    e_rs     = running_sum;
    e_halt   = decode_halted;
    e_br     = block_remaining;
    e_bwf    = block_was_full;
    have     = 1'b0;
    dec      = '0;

    if (match_count == len) begin
      if (TW'(packet_count) >= thresh) begin
        // frame too long: drop byte and held data
        res_v  = 1'b1;
        res_fe = 1'b1;
        res_st = sscfp_pkg::FS_OVERFLOW;
        match_count_next  = '0;
        packet_count_next = PW'(1);
        held_valid_next   = 1'b0;
        held_byte_next    = '0;
      end else if (in_byte == '0) begin
        // delimiter: close frame with status
        res_v  = 1'b1;
        res_fe = 1'b1;
        if (checksum_enable) begin
          res_st = (held_valid && held_byte == running_sum) ? sscfp_pkg::FS_OK
                                                            : sscfp_pkg::FS_CSUM_BAD;
        end else if (held_valid) begin
          res_byte = held_byte;
          res_dv   = 1'b1;
        end
        match_count_next  = '0;
        packet_count_next = PW'(1);
        held_valid_next   = 1'b0;
        held_byte_next    = '0;
      end else begin
        // first body byte loads the decoder from the leading code
        if (packet_count == PW'(1)) begin
          e_rs   = '0;
          e_hv   = 1'b0;
          e_hb   = '0;
          e_halt = (lead_code == '0);
          e_br   = lead_code - BW'(1);
          e_bwf  = (lead_code == '1);
        end
        packet_count_next    = packet_count + PW'(1);
        decode_halted_next   = e_halt;
        running_sum_next     = e_rs;
        held_valid_next      = e_hv;
        held_byte_next       = e_hb;
        block_remaining_next = e_br;
        block_was_full_next  = e_bwf;
        priority if (e_halt) begin
          have = 1'b1;
        end else if (e_br != '0) begin
          have = 1'b1;
          dec  = in_byte;
          block_remaining_next = e_br - BW'(1);
        end else begin
          have = !e_bwf;
          block_remaining_next = in_byte - BW'(1);
          block_was_full_next  = (in_byte == '1);
        end
        // one-byte hold: release the previous decoded byte
        if (have) begin
          held_byte_next = dec;
          if (e_hv) begin
            running_sum_next = e_rs + e_hb;
            res_v    = 1'b1;
            res_byte = e_hb;
            res_dv   = 1'b1;
          end else begin
            held_valid_next = 1'b1;
          end
        end
      end
    end else if (match_count < len) begin
      // hunting for the start sequence
      if (in_byte == expect_byte) begin
        match_count_next = match_count + MC_W'(1);
      end else begin
        lead_code_next    = in_byte - BW'(len);
        match_count_next  = '0;
        packet_count_next = PW'(1);
      end
    end else begin
      // sequence shortened under a partial match
      match_count_next  = '0;
      packet_count_next = PW'(1);
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      match_count     <= '0;
      packet_count    <= PW'(1);
      lead_code       <= '0;
      block_remaining <= '0;
      block_was_full  <= 1'b0;
      held_byte       <= '0;
      held_valid      <= 1'b0;
      running_sum     <= '0;
      decode_halted   <= 1'b0;
    end else if (advance) begin
      match_count     <= match_count_next;
      packet_count    <= packet_count_next;
      lead_code       <= lead_code_next;
      block_remaining <= block_remaining_next;
      block_was_full  <= block_was_full_next;
      held_byte       <= held_byte_next;
      held_valid      <= held_valid_next;
      running_sum     <= running_sum_next;
      decode_halted   <= decode_halted_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      frm.valid <= 1'b0;
    end else if (advance) begin
      frm.valid <= res_v;
    end else if (frm.ready) begin
      frm.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_v) begin
      frm.out_byte     <= res_byte;
      frm.data_valid   <= res_dv;
      frm.frame_end    <= res_fe;
      frm.frame_status <= res_st;
    end
  end

endmodule

@@ sv/sscfp_checker.sv @@
// port-level checks on the frame parser result channel, bound into start_seq_cobs_frame_parser
// depends on sscfp_pkg, start_seq_cobs_frame_parser_assert.svh
`include "start_seq_cobs_frame_parser_assert.svh"

module sscfp_checker (
  input logic       clk,
  input logic       rst,
  input logic       frm_valid,
  input logic       frm_ready,
  input logic [7:0] out_byte,
  input logic       data_valid,
  input logic       frame_end,
  input logic [1:0] frame_status
);

  // overflow status and the whole result payload as one word
  logic        st_overflow;
  logic [11:0] res_bits;

  assign st_overflow = (frame_status == sscfp_pkg::FS_OVERFLOW);
  assign res_bits    = {out_byte, data_valid, frame_end, frame_status};

  // every transaction carries a byte or a frame end
  `SSCFP_ASSERT_IMP(a_result_kind, frm_valid, data_valid || frame_end)

  // no byte means a zero byte field
  `SSCFP_ASSERT_IMP(a_idle_byte_zero, frm_valid && !data_valid, out_byte == 8'd0)

  // status only reported at frame end
  `SSCFP_ASSERT_IMP(a_status_at_end, frm_valid && !frame_end, frame_status == sscfp_pkg::FS_OK)

  // an aborted frame delivers no byte with its status
  `SSCFP_ASSERT_IMP(a_overflow_empty, frm_valid && st_overflow, !data_valid && frame_end)

  // stalled result holds
  `SSCFP_ASSERT_NXT(a_stall_hold, frm_valid && !frm_ready, frm_valid && $stable(res_bits))

endmodule

bind start_seq_cobs_frame_parser sscfp_checker u_sscfp_checker (
  .clk          (clk),
  .rst          (rst),
  .frm_valid    (frm.valid),
  .frm_ready    (frm.ready),
  .out_byte     (frm.out_byte),
  .data_valid   (frm.data_valid),
  .frame_end    (frm.frame_end),
  .frame_status (frm.frame_status)
);

@@ test/testbench.sv @@
// self-checking testbench for the start-sequence cobs frame parser
// depends on sscfp_pkg, sscfp_rx_if, sscfp_frame_if and start_seq_cobs_frame_parser
// directed table first, then framed random traffic checked against a local decoder
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          RANDOM_ITEMS = 800;
  localparam int          IDLE_WAIT    = 8;
  localparam int          DRAIN_LIMIT  = 4000;
  localparam int unsigned TIMEOUT_NS   = 5_000_000;
  localparam logic [31:0] DIR_SYNC     = 32'hC35AA57E;

  typedef struct packed {
    logic [sscfp_pkg::BYTE_W-1:0] out_byte;
    logic                         data_valid;
    logic                         frame_end;
    sscfp_pkg::frame_status_t     status;
  } frame_res_t;

  typedef enum logic [1:0] {
    ROW_RX,
    ROW_RX_PINNED,
    ROW_SETUP
  } row_kind_t;

  typedef struct {
    row_kind_t                    kind;
    logic [sscfp_pkg::BYTE_W-1:0] rx_val;
    frame_res_t                   res;
  } dir_row_t;

  logic                         clk = 1'b0;
  logic                         rst;
  logic                         cfg_we;
  sscfp_pkg::cfg_index_t        cfg_index;
  logic [sscfp_pkg::SYNC_W-1:0] cfg_data;

  // typed expectation carried alongside the byte of a directed row
  logic                    pin_on;
  frame_res_t              pin_res;

  sscfp_rx_if    rx ();
  sscfp_frame_if frm ();

  start_seq_cobs_frame_parser i_dut (
    .clk       (clk),
    .rst       (rst),
    .rx        (rx),
    .frm       (frm),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("CHECK FAILED");
    $finish;
  end

  // decoder state and register copy
  logic [31:0]                    m_sync;
  logic [2:0]                     m_slen;
  logic [8:0]                     m_flim;
  logic                           m_csum;
  int unsigned                    match_cnt;
  logic [sscfp_pkg::PCOUNT_W-1:0] pkt_cnt;
  logic [7:0]                     lead_code;
  logic [7:0]                     blk_rem;
  logic [7:0]                     held;
  logic [7:0]                     run_sum;
  bit                             blk_full;
  bit                             held_v;
  bit                             halted;

  frame_res_t pending_results[$];
  int         fail_count = 0;

  // generator side view of the registers
  logic [31:0] cur_sync;
  int          cur_len;
  int          cur_lim;
  bit          cur_cs;
  int          frame_bytes = 0;
  int          burst_left = 1;
  int          gap_left = 0;

  dir_row_t    dir_rows[$];

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    fail_count++;
  endtask

  function automatic void clear_frame();
    match_cnt = 0;
    pkt_cnt   = sscfp_pkg::PCOUNT_W'(1);
    held_v    = 1'b0;
    held      = 8'h00;
  endfunction

  // one received byte through the hunter and decoder; 1 when a result is due
  function automatic bit parse_byte(input logic [7:0] b, output frame_res_t res);
    int unsigned len;
    int unsigned lim;
    int unsigned thresh;
    logic [7:0]  want;
    logic [7:0]  dec;
    bit          have;
    len    = (m_slen > sscfp_pkg::SYNC_MAX_DEF) ? sscfp_pkg::SYNC_MAX_DEF : m_slen;
    lim    = (m_flim > sscfp_pkg::MAX_FRAME_DEF) ? sscfp_pkg::MAX_FRAME_DEF : m_flim;
    thresh = lim + m_csum + 2;
    res    = '0;
    if (match_cnt == len) begin
      // frame grew too long: byte dropped, frame aborted
      if (pkt_cnt >= thresh) begin
        clear_frame();
        res.frame_end = 1'b1;
        res.status    = sscfp_pkg::FS_OVERFLOW;
        return 1'b1;
      end
      // delimiter closes the frame
      if (b == 8'h00) begin
        res.frame_end = 1'b1;
        if (m_csum) begin
          res.status = (held_v && held == run_sum) ? sscfp_pkg::FS_OK
                                                   : sscfp_pkg::FS_CSUM_BAD;
        end else if (held_v) begin
          res.out_byte   = held;
          res.data_valid = 1'b1;
        end
        clear_frame();
        return 1'b1;
      end
      // first body byte starts decoding from the leading code
      if (pkt_cnt == 1) begin
        run_sum  = 8'h00;
        held_v   = 1'b0;
        held     = 8'h00;
        halted   = (lead_code == 8'h00);
        blk_rem  = lead_code - 8'd1;
        blk_full = (lead_code == 8'hFF);
      end
      pkt_cnt = pkt_cnt + 1'b1;
      have    = 1'b0;
      dec     = 8'h00;
      if (halted) begin
        have = 1'b1;
      end else if (blk_rem != 8'h00) begin
        have    = 1'b1;
        dec     = b;
        blk_rem = blk_rem - 8'd1;
      end else begin
        if (!blk_full) have = 1'b1;
        blk_rem  = b - 8'd1;
        blk_full = (b == 8'hFF);
      end
      if (have) begin
        // one-byte hold: previous decoded byte leaves now
        if (held_v) begin
          run_sum        = run_sum + held;
          res.out_byte   = held;
          res.data_valid = 1'b1;
          held           = dec;
          return 1'b1;
        end
        held   = dec;
        held_v = 1'b1;
      end
      return 1'b0;
    end
    // hunting for the start sequence
    if (match_cnt < len) begin
      want = m_sync[8*match_cnt +: 8];
      if (b == want) begin
        match_cnt++;
      end else begin
        lead_code = b - len[7:0];
        match_cnt = 0;
        pkt_cnt   = sscfp_pkg::PCOUNT_W'(1);
      end
      return 1'b0;
    end
    // match count left above a shortened sequence
    match_cnt = 0;
    pkt_cnt   = sscfp_pkg::PCOUNT_W'(1);
    return 1'b0;
  endfunction

  // monitor: register writes, result checks, then predictions for accepted bytes
  always @(posedge clk) begin
    frame_res_t want;
    frame_res_t pred;
    bit         have;
    if (rst) begin
      m_sync    = 32'h0;
      m_slen    = 3'd0;
      m_flim    = 9'd64;
      m_csum    = 1'b1;
      match_cnt = 0;
      pkt_cnt   = sscfp_pkg::PCOUNT_W'(1);
      lead_code = 8'h00;
      blk_rem   = 8'h00;
      blk_full  = 1'b0;
      held      = 8'h00;
      held_v    = 1'b0;
      run_sum   = 8'h00;
      halted    = 1'b0;
      pending_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          sscfp_pkg::CFG_SYNC_BYTES:  m_sync = cfg_data;
          sscfp_pkg::CFG_SYNC_LENGTH: m_slen = cfg_data[sscfp_pkg::SLEN_W-1:0];
          sscfp_pkg::CFG_FRAME_LIMIT: m_flim = cfg_data[sscfp_pkg::LIMIT_W-1:0];
          sscfp_pkg::CFG_CSUM_ENABLE: m_csum = cfg_data[0];
          default: ;
        endcase
      end
      if (frm.valid && frm.ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result byte %02h dv %0b end %0b status %0d",
                                    frm.out_byte, frm.data_valid, frm.frame_end,
                                    frm.frame_status));
        end else begin
          want = pending_results.pop_front();
          if (frm.out_byte !== want.out_byte)
            report_mismatch($sformatf("out_byte got %02h want %02h",
                                      frm.out_byte, want.out_byte));
          if (frm.data_valid !== want.data_valid)
            report_mismatch($sformatf("data_valid got %0b want %0b",
                                      frm.data_valid, want.data_valid));
          if (frm.frame_end !== want.frame_end)
            report_mismatch($sformatf("frame_end got %0b want %0b",
                                      frm.frame_end, want.frame_end));
          if (frm.frame_status !== want.status)
            report_mismatch($sformatf("frame_status got %0d want %0d",
                                      frm.frame_status, want.status));
        end
      end
      if (rx.valid && rx.ready) begin
        have = parse_byte(rx.rx_byte, pred);
        if (pin_on) pending_results.push_back(pin_res);
        else if (have) pending_results.push_back(pred);
      end
    end
  end

  // receiver stalls on a rotating pattern, reloaded now and then
  logic [15:0] ready_pat = 16'hFFFF;
  int          pat_left = 0;

  always @(posedge clk) begin
    if (pat_left == 0) begin
      pat_left <= $urandom_range(50, 300);
      case ($urandom_range(0, 3))
        0:       ready_pat <= 16'hFFFF;
        1:       ready_pat <= 16'($urandom) | 16'h0001;
        2:       ready_pat <= 16'($urandom | $urandom) | 16'h0001;
        default: ready_pat <= 16'h0001;
      endcase
    end else begin
      pat_left  <= pat_left - 1;
      ready_pat <= {ready_pat[14:0], ready_pat[15]};
    end
    frm.ready <= ready_pat[15];
  end

  // one rx transaction, sent in bursts with random gaps between them
  task automatic send_byte(input logic [7:0] b, input bit pinned, input frame_res_t res);
    if (gap_left > 0) begin
      rx.valid <= 1'b0;
      repeat (gap_left) @(posedge clk);
      gap_left = 0;
    end
    rx.valid   <= 1'b1;
    rx.rx_byte <= b;
    pin_on     <= pinned;
    pin_res    <= res;
    @(posedge clk);
    while (!rx.ready) @(posedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 60);
      gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
    end
  endtask

  // stop sending and let every expected result arrive
  task automatic wait_drained();
    int spin;
    rx.valid <= 1'b0;
    spin = 0;
    // let the monitor log the last accepted byte before checking
    @(posedge clk);
    while (pending_results.size() != 0 && spin < DRAIN_LIMIT) begin
      @(posedge clk);
      spin++;
    end
    repeat (IDLE_WAIT) @(posedge clk);
    if (pending_results.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
      pending_results.delete();
    end
  endtask

  task automatic apply_config(input logic [31:0] sb, input int sl, input int fl, input bit ce);
    cfg_we    <= 1'b1;
    cfg_index <= sscfp_pkg::CFG_SYNC_BYTES;
    cfg_data  <= sb;
    @(posedge clk);
    cfg_index <= sscfp_pkg::CFG_SYNC_LENGTH;
    cfg_data  <= 32'(sl);
    @(posedge clk);
    cfg_index <= sscfp_pkg::CFG_FRAME_LIMIT;
    cfg_data  <= 32'(fl);
    @(posedge clk);
    cfg_index <= sscfp_pkg::CFG_CSUM_ENABLE;
    cfg_data  <= 32'(ce);
    @(posedge clk);
    cfg_we   <= 1'b0;
    cur_sync = sb;
    cur_len  = (sl > sscfp_pkg::SYNC_MAX_DEF) ? sscfp_pkg::SYNC_MAX_DEF : sl;
    cur_lim  = (fl > sscfp_pkg::MAX_FRAME_DEF) ? sscfp_pkg::MAX_FRAME_DEF : fl;
    cur_cs   = ce;
  endtask

  // cobs-encode a random message, wrap it in lead byte and sync (when a sequence is set) and delimiter
  task automatic send_frame(input int n, input int zero_odds, input bit broken);
    logic [7:0] msg[$];
    logic [7:0] enc[$];
    logic [7:0] seq[$];
    logic [7:0] b;
    logic [7:0] csum;
    logic [7:0] junk;
    int         code_pos;
    int         code;
    csum = 8'h00;
    for (int i = 0; i < n; i++) begin
      if (zero_odds != 0 && $urandom_range(0, zero_odds - 1) == 0) b = 8'h00;
      else b = 8'($urandom_range(1, 255));
      msg.push_back(b);
      csum = csum + b;
    end
    // checksum byte, now and then spoilt
    if (cur_cs) begin
      if ($urandom_range(0, 7) == 0) begin
        junk = 8'($urandom_range(1, 255));
        csum = csum ^ junk;
      end
      msg.push_back(csum);
    end
    enc.push_back(8'h00);
    code_pos = 0;
    code     = 1;
    foreach (msg[i]) begin
      if (msg[i] == 8'h00) begin
        enc[code_pos] = code[7:0];
        code_pos      = enc.size();
        enc.push_back(8'h00);
        code = 1;
      end else begin
        enc.push_back(msg[i]);
        code++;
        if (code == 255) begin
          enc[code_pos] = 8'hFF;
          code_pos      = enc.size();
          enc.push_back(8'h00);
          code = 1;
        end
      end
    end
    enc[code_pos] = code[7:0];
    // leading code rides on the mismatching byte ahead of the sequence
    if (cur_len > 0) begin
      b = enc[0] + cur_len[7:0];
      seq.push_back(b);
      for (int k = 0; k < cur_len; k++) seq.push_back(cur_sync[8*k +: 8]);
    end
    for (int i = 1; i < enc.size(); i++) seq.push_back(enc[i]);
    seq.push_back(8'h00);
    if (broken) begin
      junk = 8'($urandom_range(0, 255));
      seq[$urandom_range(0, seq.size() - 1)] = junk;
    end
    foreach (seq[i]) send_byte(seq[i], 1'b0, '0);
    frame_bytes += seq.size();
  endtask

  task automatic add_row(input row_kind_t kind, input logic [7:0] b, input logic [7:0] ob,
                         input logic dv, input logic fe, input sscfp_pkg::frame_status_t st);
    dir_row_t r;
    r.kind           = kind;
    r.rx_val         = b;
    r.res.out_byte   = ob;
    r.res.data_valid = dv;
    r.res.frame_end  = fe;
    r.res.status     = st;
    dir_rows.push_back(r);
  endtask

  initial begin
    int          n;
    int          sel;
    int          pick;
    int          phase;
    int          phase_end;
    int          zero_odds;
    int          sl;
    int          fl;
    bit          ce;
    logic [31:0] sb;
    rst        <= 1'b1;
    rx.valid   <= 1'b0;
    rx.rx_byte <= 8'h00;
    pin_on     <= 1'b0;
    pin_res    <= '0;
    cfg_we     <= 1'b0;
    cfg_index  <= sscfp_pkg::CFG_SYNC_BYTES;
    cfg_data   <= 32'h0;
    cur_sync = 32'h0;
    cur_len  = 0;
    cur_lim  = 64;
    cur_cs   = 1'b1;

    // reset registers: no sequence, leading code zero, checksum on
    add_row(ROW_RX_PINNED, 8'h00, 8'h00, 1'b0, 1'b1, sscfp_pkg::FS_CSUM_BAD);
    add_row(ROW_RX_PINNED, 8'h00, 8'h00, 1'b0, 1'b1, sscfp_pkg::FS_CSUM_BAD);
    add_row(ROW_RX,        8'h37, 8'h00, 1'b0, 1'b0, sscfp_pkg::FS_OK);
    add_row(ROW_RX_PINNED, 8'hFF, 8'h00, 1'b1, 1'b0, sscfp_pkg::FS_OK);
    add_row(ROW_RX_PINNED, 8'h00, 8'h00, 1'b0, 1'b1, sscfp_pkg::FS_OK);
    // two-byte sequence, limit two, checksum on
    add_row(ROW_SETUP,     8'h00, 8'h00, 1'b0, 1'b0, sscfp_pkg::FS_OK);
    // good frame carrying 10 00 with checksum 10
    add_row(ROW_RX,        8'h04, 8'h00, 1'b0, 1'b0, sscfp_pkg::FS_OK);
    add_row(ROW_RX,        8'h7E, 8'h00, 1'b0, 1'b0, sscfp_pkg::FS_OK);
    add_row(ROW_RX,        8'hA5, 8'h00, 1'b0, 1'b0, sscfp_pkg::FS_OK);
    add_row(ROW_RX,        8'h10, 8'h00, 1'b0, 1'b0, sscfp_pkg::FS_OK);
    add_row(ROW_RX,        8'h02, 8'h00, 1'b0, 1'b0, sscfp_pkg::FS_OK);
    add_row(ROW_RX,        8'h10, 8'h00, 1'b0, 1'b0, sscfp_pkg::FS_OK);
    add_row(ROW_RX_PINNED, 8'h00, 8'h00, 1'b0, 1'b1, sscfp_pkg::FS_OK);
    // full block running past the limit
    add_row(ROW_RX,        8'h01, 8'h00, 1'b0, 1'b0, sscfp_pkg::FS_OK);
    add_row(ROW_RX,        8'h7E, 8'h00, 1'b0, 1'b0, sscfp_pkg::FS_OK);
    add_row(ROW_RX,        8'hA5, 8'h00, 1'b0, 1'b0, sscfp_pkg::FS_OK);
    add_row(ROW_RX,        8'h11, 8'h00, 1'b0, 1'b0, sscfp_pkg::FS_OK);
    add_row(ROW_RX,        8'h22, 8'h00, 1'b0, 1'b0, sscfp_pkg::FS_OK);
    add_row(ROW_RX,        8'h33, 8'h00, 1'b0, 1'b0, sscfp_pkg::FS_OK);
    add_row(ROW_RX,        8'h44, 8'h00, 1'b0, 1'b0, sscfp_pkg::FS_OK);
    add_row(ROW_RX_PINNED, 8'h55, 8'h00, 1'b0, 1'b1, sscfp_pkg::FS_OVERFLOW);
    // message 05 with a wrong checksum 07
    add_row(ROW_RX,        8'h05, 8'h00, 1'b0, 1'b0, sscfp_pkg::FS_OK);
    add_row(ROW_RX,        8'h7E, 8'h00, 1'b0, 1'b0, sscfp_pkg::FS_OK);
    add_row(ROW_RX,        8'hA5, 8'h00, 1'b0, 1'b0, sscfp_pkg::FS_OK);
    add_row(ROW_RX,        8'h05, 8'h00, 1'b0, 1'b0, sscfp_pkg::FS_OK);
    add_row(ROW_RX,        8'h07, 8'h00, 1'b0, 1'b0, sscfp_pkg::FS_OK);
    add_row(ROW_RX_PINNED, 8'h00, 8'h00, 1'b0, 1'b1, sscfp_pkg::FS_CSUM_BAD);

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    foreach (dir_rows[i]) begin
      case (dir_rows[i].kind)
        ROW_SETUP: begin
          wait_drained();
          apply_config(DIR_SYNC, 2, 2, 1'b1);
        end
        ROW_RX_PINNED: send_byte(dir_rows[i].rx_val, 1'b1, dir_rows[i].res);
        default:       send_byte(dir_rows[i].rx_val, 1'b0, '0);
      endcase
    end

    // random phases, each under its own register setting
    phase = 0;
    while (frame_bytes < RANDOM_ITEMS || phase < 6) begin
      wait_drained();
      case (phase)
        0: begin sb = 32'hFFFFFFFF; sl = 7; fl = 511; ce = 1'b0; end
        1: begin sb = 32'h0;        sl = 0; fl = 1;   ce = 1'b1; end
        2: begin sb = $urandom;     sl = 4; fl = 256; ce = 1'b1; end
        3: begin sb = $urandom;     sl = 1; fl = $urandom_range(1, 32); ce = 1'b0; end
        default: begin
          sb = ($urandom_range(0, 4) == 0) ? 32'h0 : $urandom;
          sl = $urandom_range(0, 7);
          fl = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 511) : $urandom_range(1, 40);
          ce = 1'($urandom_range(0, 1));
        end
      endcase
      apply_config(sb, sl, fl, ce);
      phase_end = frame_bytes + $urandom_range(20, 60);
      // long limits get one zero-free frame, so it opens with a full 254-byte block
      if (cur_lim >= 254) send_frame(cur_lim, 0, 1'b0);
      while (frame_bytes < phase_end) begin
        pick = $urandom_range(0, 19);
        sel  = $urandom_range(0, 9);
        if (sel < 7 || cur_lim > 40) n = $urandom_range(0, (cur_lim < 12) ? cur_lim : 12);
        else n = $urandom_range((cur_lim > 2) ? cur_lim - 2 : 0, cur_lim + 2);
        zero_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 8);
        if (pick < 2) begin
          // line noise
          repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
        end else if (pick < 4) begin
          send_frame(n, zero_odds, 1'b1);
        end else if (pick == 4) begin
          wait_drained();
        end else begin
          send_frame(n, zero_odds, 1'b0);
        end
      end
      phase++;
    end

    wait_drained();
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ start_seq_cobs_frame_parser.f @@
+incdir+sv
sv/sscfp_pkg.sv
sv/sscfp_rx_if.sv
sv/sscfp_frame_if.sv
sv/start_seq_cobs_frame_parser.sv
sv/sscfp_checker.sv
test/testbench.sv
